### rtl/plcm_pkg.sv
package plcm_pkg;

	localparam int IN_W          = 32;
	localparam int PT_W          = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int STORED_POINTS = 10;
	localparam int QUEUE_DEPTH   = 4;
	localparam int FRAC_W        = 16;
	localparam int RES_W         = 20;

	localparam logic signed [RES_W-1:0] OUT_MAX = 20'sd32767;
	localparam logic signed [RES_W-1:0] OUT_MIN = -20'sd32768;

	localparam logic [31:0] INPUT_MIN_RST  = 32'd0;
	localparam logic [31:0] INPUT_MAX_RST  = 32'd6553600;
	localparam logic [63:0] CURVE_LOW_RST  = 64'd2401850410527358976;
	localparam logic [63:0] CURVE_MID_RST  = 64'd5604521564424776818;
	localparam logic [31:0] CURVE_HIGH_RST = 32'd1677744356;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_MIN  = 3'd0,
		REG_INPUT_MAX  = 3'd1,
		REG_CURVE_LOW  = 3'd2,
		REG_CURVE_MID  = 3'd3,
		REG_CURVE_HIGH = 3'd4,
		REG_INVERT     = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_LAST   = 2'd1,
		KIND_INTERP = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] input_min;
		logic [31:0] input_max;
		logic [63:0] curve_low;
		logic [63:0] curve_mid;
		logic [31:0] curve_high;
		logic        invert;
	} cfg_t;

	function automatic logic [PT_W-1:0] curve_point(cfg_t cfg, int unsigned idx);
		logic [PT_W*STORED_POINTS-1:0] flat;
		flat = {cfg.curve_high, cfg.curve_mid, cfg.curve_low};
		if (idx < STORED_POINTS) begin
			return flat[idx*PT_W +: PT_W];
		end
		return '0;
	endfunction

endpackage

### rtl/plcm_regs.sv
module plcm_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [plcm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plcm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output plcm_pkg::cfg_t                     cfg
);

	plcm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_min  <= plcm_pkg::INPUT_MIN_RST;
			cfg_q.input_max  <= plcm_pkg::INPUT_MAX_RST;
			cfg_q.curve_low  <= plcm_pkg::CURVE_LOW_RST;
			cfg_q.curve_mid  <= plcm_pkg::CURVE_MID_RST;
			cfg_q.curve_high <= plcm_pkg::CURVE_HIGH_RST;
			cfg_q.invert     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (plcm_pkg::reg_index_t'(cfg_index))
				plcm_pkg::REG_INPUT_MIN: begin
					cfg_q.input_min <= cfg_data[31:0];
				end
				plcm_pkg::REG_INPUT_MAX: begin
					cfg_q.input_max <= cfg_data[31:0];
				end
				plcm_pkg::REG_CURVE_LOW: begin
					cfg_q.curve_low <= cfg_data;
				end
				plcm_pkg::REG_CURVE_MID: begin
					cfg_q.curve_mid <= cfg_data;
				end
				plcm_pkg::REG_CURVE_HIGH: begin
					cfg_q.curve_high <= cfg_data[31:0];
				end
				plcm_pkg::REG_INVERT: begin
					cfg_q.invert <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/plcm_front.sv
module plcm_front #(
	parameter int CURVE_POINTS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [plcm_pkg::IN_W-1:0]       in_value,
	input  plcm_pkg::cfg_t                  cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output plcm_pkg::kind_t                 out_kind,
	output logic [31+((CURVE_POINTS > 2) ? $clog2(CURVE_POINTS-1) : 1):0] out_pos,
	output logic [31:0]                     out_range
);

	localparam int KW = (CURVE_POINTS > 2) ? $clog2(CURVE_POINTS-1) : 1;
	localparam int TW = 32 + KW;
	localparam logic [TW-1:0] SCALE = TW'(CURVE_POINTS - 1);

	logic            valid_s1;
	plcm_pkg::kind_t kind_s1;
	logic [31:0]     diff_s1;
	logic [31:0]     range_s1;

	plcm_pkg::kind_t kind_c;
	logic [32:0]     diff_c;
	logic [32:0]     range_c;

	always_comb begin
		if ($signed(in_value) <= $signed(cfg.input_min)) begin
			kind_c = plcm_pkg::KIND_FIRST;
		end else if ($signed(in_value) >= $signed(cfg.input_max)) begin
			kind_c = plcm_pkg::KIND_LAST;
		end else begin
			kind_c = plcm_pkg::KIND_INTERP;
		end
		diff_c  = {in_value[31], in_value} - {cfg.input_min[31], cfg.input_min};
		range_c = {cfg.input_max[31], cfg.input_max} - {cfg.input_min[31], cfg.input_min};
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_kind  = kind_s1;
	assign out_range = range_s1;
	assign out_pos   = TW'(diff_s1) * SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind_c;
			diff_s1  <= diff_c[31:0];
			range_s1 <= range_c[31:0];
		end
	end

endmodule

### rtl/plcm_fifo.sv
module plcm_fifo #(
	parameter int WIDTH = 70
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int DEPTH = plcm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/plcm_back.sv
module plcm_back #(
	parameter int CURVE_POINTS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  plcm_pkg::kind_t              in_kind,
	input  logic [31+((CURVE_POINTS > 2) ? $clog2(CURVE_POINTS-1) : 1):0] in_pos,
	input  logic [31:0]                  in_range,
	input  plcm_pkg::cfg_t               cfg,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [plcm_pkg::PT_W-1:0]    out_value
);

	localparam int KW    = (CURVE_POINTS > 2) ? $clog2(CURVE_POINTS-1) : 1;
	localparam int TW    = 32 + KW;
	localparam int QW    = plcm_pkg::FRAC_W;
	localparam int PW    = plcm_pkg::PT_W + 32;
	localparam int PT_W  = plcm_pkg::PT_W;
	localparam int RES_W = plcm_pkg::RES_W;
	localparam int NSEG  = CURVE_POINTS - 1;
	localparam logic [KW-1:0] KMAX = KW'(CURVE_POINTS - 2);

	logic en;

	logic [2*PT_W-1:0] pair_tbl [NSEG];
	logic [PT_W-1:0]   first_pt;
	logic [PT_W-1:0]   last_pt;

	// Segment search: restoring division of the scaled position by the range.
	logic            d1_valid_in [KW];
	plcm_pkg::kind_t d1_kind_in  [KW];
	logic [TW-1:0]   d1_rem_in   [KW];
	logic [KW-1:0]   d1_quo_in   [KW];
	logic [31:0]     d1_range_in [KW];
	logic [TW-1:0]   d1_div      [KW];
	logic            d1_ge       [KW];
	logic            d1_valid_s  [KW];
	plcm_pkg::kind_t d1_kind_s   [KW];
	logic [TW-1:0]   d1_rem_s    [KW];
	logic [KW-1:0]   d1_quo_s    [KW];
	logic [31:0]     d1_range_s  [KW];

	logic              valid_sm;
	plcm_pkg::kind_t   kind_sm;
	logic [PT_W-1:0]   a_sm;
	logic              neg_sm;
	logic [PT_W-1:0]   mag_sm;
	logic [31:0]       r_sm;
	logic [31:0]       range_sm;

	logic              valid_sp;
	plcm_pkg::kind_t   kind_sp;
	logic [PT_W-1:0]   a_sp;
	logic              neg_sp;
	logic [PW-1:0]     prod_sp;
	logic [31:0]       range_sp;

	// Fraction: restoring division of the scaled step by the range.
	logic            d2_valid_in [QW];
	plcm_pkg::kind_t d2_kind_in  [QW];
	logic [PW-1:0]   d2_rem_in   [QW];
	logic [QW-1:0]   d2_quo_in   [QW];
	logic [31:0]     d2_range_in [QW];
	logic [PT_W-1:0] d2_a_in     [QW];
	logic            d2_neg_in   [QW];
	logic [PW-1:0]   d2_div      [QW];
	logic            d2_ge       [QW];
	logic            d2_valid_s  [QW];
	plcm_pkg::kind_t d2_kind_s   [QW];
	logic [PW-1:0]   d2_rem_s    [QW];
	logic [QW-1:0]   d2_quo_s    [QW];
	logic [31:0]     d2_range_s  [QW];
	logic [PT_W-1:0] d2_a_s      [QW];
	logic            d2_neg_s    [QW];

	logic              valid_sr;
	plcm_pkg::kind_t   kind_sr;
	logic [PT_W-1:0]   a_sr;
	logic              neg_sr;
	logic [QW:0]       q_sr;

	logic              out_valid_q;
	logic [PT_W-1:0]   out_value_q;

	logic [KW-1:0]     kc;
	logic [2*PT_W-1:0] pair_c;
	logic [PT_W:0]     delta_c;
	logic [PT_W:0]     absd_c;
	logic [32:0]       twice_rem_c;
	logic signed [RES_W-1:0] a_ext;
	logic signed [RES_W-1:0] q_ext;
	logic signed [RES_W-1:0] first_ext;
	logic signed [RES_W-1:0] last_ext;
	logic signed [RES_W-1:0] v_c;
	logic signed [RES_W-1:0] w_c;
	logic [PT_W-1:0]         sat_c;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

	assign first_pt = plcm_pkg::curve_point(cfg, 0);
	assign last_pt  = plcm_pkg::curve_point(cfg, CURVE_POINTS - 1);

	for (genvar j = 0; j < NSEG; j++) begin : g_pair
		assign pair_tbl[j] = {plcm_pkg::curve_point(cfg, j + 1),
			plcm_pkg::curve_point(cfg, j)};
	end

	for (genvar j = 0; j < KW; j++) begin : g_seg
		if (j == 0) begin : g_head
			assign d1_valid_in[j] = in_valid;
			assign d1_kind_in[j]  = in_kind;
			assign d1_rem_in[j]   = in_pos;
			assign d1_quo_in[j]   = '0;
			assign d1_range_in[j] = in_range;
		end else begin : g_tail
			assign d1_valid_in[j] = d1_valid_s[j-1];
			assign d1_kind_in[j]  = d1_kind_s[j-1];
			assign d1_rem_in[j]   = d1_rem_s[j-1];
			assign d1_quo_in[j]   = d1_quo_s[j-1];
			assign d1_range_in[j] = d1_range_s[j-1];
		end

		assign d1_div[j] = TW'(d1_range_in[j]) << (KW - 1 - j);
		assign d1_ge[j]  = (d1_rem_in[j] >= d1_div[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_valid_s[j] <= 1'b0;
			end else if (en) begin
				d1_valid_s[j] <= d1_valid_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_kind_s[j]  <= d1_kind_in[j];
				d1_range_s[j] <= d1_range_in[j];
				d1_rem_s[j]   <= d1_ge[j] ? d1_rem_in[j] - d1_div[j] : d1_rem_in[j];
				d1_quo_s[j]   <= d1_quo_in[j] | (KW'(d1_ge[j]) << (KW - 1 - j));
			end
		end
	end

	always_comb begin
		kc      = (d1_quo_s[KW-1] > KMAX) ? KMAX : d1_quo_s[KW-1];
		pair_c  = pair_tbl[kc];
		delta_c = {pair_c[2*PT_W-1], pair_c[2*PT_W-1:PT_W]}
			- {pair_c[PT_W-1], pair_c[PT_W-1:0]};
		absd_c  = delta_c[PT_W] ? -delta_c : delta_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sm <= 1'b0;
			valid_sp <= 1'b0;
			valid_sr <= 1'b0;
		end else if (en) begin
			valid_sm <= d1_valid_s[KW-1];
			valid_sp <= valid_sm;
			valid_sr <= d2_valid_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_sm  <= d1_kind_s[KW-1];
			a_sm     <= pair_c[PT_W-1:0];
			neg_sm   <= delta_c[PT_W];
			mag_sm   <= absd_c[PT_W-1:0];
			r_sm     <= d1_rem_s[KW-1][31:0];
			range_sm <= d1_range_s[KW-1];

			kind_sp  <= kind_sm;
			a_sp     <= a_sm;
			neg_sp   <= neg_sm;
			prod_sp  <= PW'(mag_sm) * PW'(r_sm);
			range_sp <= range_sm;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_frac
		if (j == 0) begin : g_head
			assign d2_valid_in[j] = valid_sp;
			assign d2_kind_in[j]  = kind_sp;
			assign d2_rem_in[j]   = prod_sp;
			assign d2_quo_in[j]   = '0;
			assign d2_range_in[j] = range_sp;
			assign d2_a_in[j]     = a_sp;
			assign d2_neg_in[j]   = neg_sp;
		end else begin : g_tail
			assign d2_valid_in[j] = d2_valid_s[j-1];
			assign d2_kind_in[j]  = d2_kind_s[j-1];
			assign d2_rem_in[j]   = d2_rem_s[j-1];
			assign d2_quo_in[j]   = d2_quo_s[j-1];
			assign d2_range_in[j] = d2_range_s[j-1];
			assign d2_a_in[j]     = d2_a_s[j-1];
			assign d2_neg_in[j]   = d2_neg_s[j-1];
		end

		assign d2_div[j] = PW'(d2_range_in[j]) << (QW - 1 - j);
		assign d2_ge[j]  = (d2_rem_in[j] >= d2_div[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_valid_s[j] <= 1'b0;
			end else if (en) begin
				d2_valid_s[j] <= d2_valid_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_kind_s[j]  <= d2_kind_in[j];
				d2_range_s[j] <= d2_range_in[j];
				d2_a_s[j]     <= d2_a_in[j];
				d2_neg_s[j]   <= d2_neg_in[j];
				d2_rem_s[j]   <= d2_ge[j] ? d2_rem_in[j] - d2_div[j] : d2_rem_in[j];
				d2_quo_s[j]   <= d2_quo_in[j] | (QW'(d2_ge[j]) << (QW - 1 - j));
			end
		end
	end

	// The remainder is below the range, so it fits 32 bits; a remainder of
	// at least half the range rounds the fraction up.
	assign twice_rem_c = {d2_rem_s[QW-1][31:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			kind_sr <= d2_kind_s[QW-1];
			a_sr    <= d2_a_s[QW-1];
			neg_sr  <= d2_neg_s[QW-1];
			q_sr    <= {1'b0, d2_quo_s[QW-1]}
				+ (QW+1)'(twice_rem_c >= {1'b0, d2_range_s[QW-1]});
		end
	end

	always_comb begin
		a_ext     = {{(RES_W-PT_W){a_sr[PT_W-1]}}, a_sr};
		q_ext     = {{(RES_W-QW-1){1'b0}}, q_sr};
		first_ext = {{(RES_W-PT_W){first_pt[PT_W-1]}}, first_pt};
		last_ext  = {{(RES_W-PT_W){last_pt[PT_W-1]}}, last_pt};
		case (kind_sr)
			plcm_pkg::KIND_FIRST: begin
				v_c = first_ext;
			end
			plcm_pkg::KIND_LAST: begin
				v_c = last_ext;
			end
			default: begin
				v_c = neg_sr ? a_ext - q_ext : a_ext + q_ext;
			end
		endcase
		w_c = cfg.invert ? first_ext + last_ext - v_c : v_c;
		if (w_c > plcm_pkg::OUT_MAX) begin
			sat_c = plcm_pkg::OUT_MAX[PT_W-1:0];
		end else if (w_c < plcm_pkg::OUT_MIN) begin
			sat_c = plcm_pkg::OUT_MIN[PT_W-1:0];
		end else begin
			sat_c = w_c[PT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_value_q <= sat_c;
		end
	end

endmodule

### rtl/piecewise_linear_curve_map_top.sv
// Throughput: one transaction per cycle while m_axis_tready does not stall the output, set by
// the two pipelined dividers that resolve one quotient bit per stage (segment, then fraction).
// A four-entry queue separates the input stage from the divider pipeline.
// Reset: asynchronous, active low; registers return to their defaults and all
// valid bits and queue pointers clear; data registers are not reset.
module piecewise_linear_curve_map_top #(
	parameter int CURVE_POINTS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] in_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] out_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int KW   = (CURVE_POINTS > 2) ? $clog2(CURVE_POINTS-1) : 1;
	localparam int TW   = 32 + KW;
	localparam int KD_W = $bits(plcm_pkg::kind_t);
	localparam int QD_W = KD_W + TW + 32;

	plcm_pkg::cfg_t  cfg;
	logic            fr_valid;
	logic            fr_ready;
	plcm_pkg::kind_t fr_kind;
	logic [TW-1:0]   fr_pos;
	logic [31:0]     fr_range;
	logic            qu_valid;
	logic            qu_ready;
	logic [QD_W-1:0] qu_data;

	plcm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plcm_front #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.cfg       (cfg),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_kind  (fr_kind),
		.out_pos   (fr_pos),
		.out_range (fr_range)
	);

	plcm_fifo #(
		.WIDTH (QD_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  ({fr_kind, fr_pos, fr_range}),
		.rd_valid (qu_valid),
		.rd_ready (qu_ready),
		.rd_data  (qu_data)
	);

	plcm_back #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qu_valid),
		.in_ready  (qu_ready),
		.in_kind   (plcm_pkg::kind_t'(qu_data[QD_W-1 -: KD_W])),
		.in_pos    (qu_data[TW+31:32]),
		.in_range  (qu_data[31:0]),
		.cfg       (cfg),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata)
	);

endmodule

### rtl/plcm_checker.sv
module plcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic [5:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 6'(in_acc) - 6'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 6'd0)
		else $error("result presented with no transaction outstanding");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 6'd0 |-> s_axis_tready)
		else $error("empty block refused an input transaction");

	a_one_per_in: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 6'd1 && out_acc && !in_acc |=> !m_axis_tvalid)
		else $error("more results than input transactions");

endmodule

bind piecewise_linear_curve_map_top plcm_checker u_checker (.*);

### dv/tb_piecewise_linear_curve_map_top.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_curve_map_top;

	localparam int NUM_POINTS = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 13;
	localparam int VALUES_PER_PHASE = 148;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;
	localparam logic [plcm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [plcm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// Shadow copy of the map settings.
	logic [31:0] mdl_min;
	logic [31:0] mdl_max;
	logic [63:0] mdl_low;
	logic [63:0] mdl_mid;
	logic [31:0] mdl_high;
	logic        mdl_inv;

	logic [31:0] value_queue[$];
	logic [15:0] out_expected[$];

	int unsigned items_pushed = 0;
	int unsigned acc_in_cnt = 0;
	int unsigned acc_out_cnt = 0;
	int unsigned cfg_acc_cnt = 0;
	int unsigned settings_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned src_max_gap = 0;
	int unsigned sink_max_gap = 0;
	int unsigned rx_hold = 0;
	int unsigned drv_seen = 0;
	int unsigned drv_gap = 0;
	int unsigned rx_seen = 0;
	int unsigned rx_gap = 0;
	int unsigned last_progress = 0;
	int unsigned idle_cycles = 0;

	piecewise_linear_curve_map_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint curve_pt(int unsigned idx);
		logic [159:0] pts;
		longint v;
		pts = {mdl_high, mdl_mid, mdl_low};
		v = $signed(pts[idx*16 +: 16]);
		return v;
	endfunction

	function automatic logic [15:0] curve_map_out(logic [31:0] din);
		longint x, lo, hi, first, last, v, a, b, delta;
		longint unsigned span, t, r, mag, q;
		int unsigned k;
		x = $signed(din);
		lo = $signed(mdl_min);
		hi = $signed(mdl_max);
		first = curve_pt(0);
		last = curve_pt(NUM_POINTS - 1);
		if (x <= lo) begin
			v = first;
		end else if (x >= hi) begin
			v = last;
		end else begin
			span = hi - lo;
			t = (x - lo) * (NUM_POINTS - 1);
			k = t / span;
			r = t % span;
			if (k > NUM_POINTS - 2) begin
				k = NUM_POINTS - 2;
			end
			a = curve_pt(k);
			b = curve_pt(k + 1);
			delta = b - a;
			mag = (delta < 0) ? -delta : delta;
			q = (2 * mag * r + span) / (2 * span);
			v = (delta < 0) ? a - q : a + q;
		end
		if (mdl_inv) begin
			v = last - (v - first);
		end
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return v[15:0];
	endfunction

	task automatic note_fail(string msg);
		if (fail_cnt < 10) begin
			$display("%0t ns: %s", $realtime, msg);
		end
		fail_cnt++;
	endtask

	// Value driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || acc_in_cnt != drv_seen) begin
				drv_seen = acc_in_cnt;
				if (drv_gap > 0) begin
					drv_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (value_queue.size() != 0) begin
					s_axis_tdata <= value_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					drv_gap = $urandom_range(0, src_max_gap);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (acc_out_cnt != rx_seen) begin
				rx_seen = acc_out_cnt;
				rx_gap = $urandom_range(0, sink_max_gap);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor and checker.
	always @(posedge clk) begin
		logic [15:0] exp_v;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				out_expected.push_back(curve_map_out(s_axis_tdata));
				acc_in_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				acc_out_cnt++;
				if (out_expected.size() == 0) begin
					note_fail($sformatf("Unexpected output transaction, out_value 0x%04h",
						m_axis_tdata));
				end else begin
					exp_v = out_expected.pop_front();
					if (m_axis_tdata !== exp_v) begin
						note_fail($sformatf("out_value mismatch: expected 0x%04h, got 0x%04h",
							exp_v, m_axis_tdata));
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		int unsigned progress;
		if (arst_n) begin
			progress = acc_in_cnt + acc_out_cnt + cfg_acc_cnt;
			if (progress != last_progress || (out_expected.size() == 0 &&
					acc_in_cnt == items_pushed && !cfg_valid)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			last_progress = progress;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results pending",
					idle_cycles, out_expected.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			plcm_pkg::REG_INPUT_MIN:  mdl_min = val[31:0];
			plcm_pkg::REG_INPUT_MAX:  mdl_max = val[31:0];
			plcm_pkg::REG_CURVE_LOW:  mdl_low = val;
			plcm_pkg::REG_CURVE_MID:  mdl_mid = val;
			plcm_pkg::REG_CURVE_HIGH: mdl_high = val[31:0];
			plcm_pkg::REG_INVERT:     mdl_inv = val[0];
			default: ;
		endcase
		cfg_acc_cnt++;
	endtask

	// Unused upper bits carry random data, and a spare index is written too.
	task automatic set_config(logic [31:0] mn, logic [31:0] mx, logic [63:0] lw,
			logic [63:0] md, logic [31:0] hg, logic inv);
		write_reg(plcm_pkg::REG_INPUT_MIN, {$urandom, mn});
		write_reg(plcm_pkg::REG_INPUT_MAX, {$urandom, mx});
		write_reg(plcm_pkg::REG_CURVE_LOW, lw);
		write_reg(plcm_pkg::REG_CURVE_MID, md);
		write_reg(plcm_pkg::REG_CURVE_HIGH, {$urandom, hg});
		write_reg(plcm_pkg::REG_INVERT, {$urandom, 31'($urandom), inv});
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	task automatic wait_drained();
		while (acc_in_cnt != items_pushed || out_expected.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_value(longint x);
		if (x > MAX32) begin
			x = MAX32;
		end
		if (x < MIN32) begin
			x = MIN32;
		end
		value_queue.push_back(x[31:0]);
		items_pushed++;
	endtask

	task automatic push_random(longint lo, longint hi);
		int unsigned sel;
		longint unsigned u;
		longint x;
		sel = $urandom_range(0, 9);
		u = $urandom;
		if (hi > lo && sel < 7) begin
			x = lo + (u % (hi - lo + 1));
		end else if (hi > lo && sel == 7) begin
			x = lo + ((hi - lo) * $urandom_range(1, 8)) / 9 + $urandom_range(0, 2) - 1;
		end else if (sel >= 7 && sel <= 8) begin
			x = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 4) - 2;
		end else begin
			x = $signed($urandom);
		end
		push_value(x);
	endtask

	initial begin
		longint lo, hi;
		int unsigned mode;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mdl_min = plcm_pkg::INPUT_MIN_RST;
		mdl_max = plcm_pkg::INPUT_MAX_RST;
		mdl_low = plcm_pkg::CURVE_LOW_RST;
		mdl_mid = plcm_pkg::CURVE_MID_RST;
		mdl_high = plcm_pkg::CURVE_HIGH_RST;
		mdl_inv = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: range 0.0 to 100.0 over an even ramp.
		@(posedge clk);
		src_max_gap = 7;
		sink_max_gap = 7;
		push_value(MIN32);
		push_value(MAX32);
		push_value(0);
		push_value(1);
		push_value(6553599);
		push_value(6553600);
		push_value(2184533);
		push_value(3276800);

		// Full input range, alternating extreme points, mirrored so it saturates high.
		wait_drained();
		set_config(MIN32[31:0], MAX32[31:0], 64'h8000_7fff_8000_7fff,
			64'h8000_7fff_8000_7fff, 32'h7fff_7fff, 1'b1);
		@(posedge clk);
		push_value(MIN32);
		push_value(MAX32);
		push_value(0);
		push_value(MIN32 + 1);

		// Same with the low end, so the mirror saturates low.
		wait_drained();
		set_config(MIN32[31:0], MAX32[31:0], 64'h7fff_8000_7fff_8000,
			64'h7fff_8000_7fff_8000, 32'h8000_8000, 1'b1);
		@(posedge clk);
		push_value(0);
		push_value(-64'sd1073741824);
		push_value(64'sd1073741824);

		// Reversed range takes no division.
		wait_drained();
		set_config(32'd6553600, -32'sd6553600, plcm_pkg::CURVE_LOW_RST,
			plcm_pkg::CURVE_MID_RST, plcm_pkg::CURVE_HIGH_RST, 1'b0);
		@(posedge clk);
		push_value(6553600);
		push_value(6553599);
		push_value(6553601);
		push_value(0);

		// Narrowest range with an interior point.
		wait_drained();
		set_config(-32'sd3, -32'sd1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b1);
		@(posedge clk);
		push_value(-4);
		push_value(-3);
		push_value(-2);
		push_value(-1);
		push_value(0);

		// Empty range.
		wait_drained();
		set_config(32'd12345, 32'd12345, {$urandom, $urandom}, {$urandom, $urandom},
			$urandom, 1'b0);
		@(posedge clk);
		push_value(12345);
		push_value(12346);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			mode = $urandom_range(0, 5);
			case (mode)
				0: begin
					lo = $signed($urandom);
					hi = $signed($urandom);
				end
				4: begin
					lo = MIN32;
					hi = MAX32;
				end
				5: begin
					if ($urandom_range(0, 1)) begin
						lo = MIN32;
						hi = $signed($urandom);
					end else begin
						lo = $signed($urandom);
						hi = MAX32;
					end
				end
				default: begin
					lo = $urandom_range(0, 20000000);
					lo = lo - 10000000;
					hi = $urandom_range(1, 1 << $urandom_range(1, 24));
					hi = lo + hi;
				end
			endcase
			set_config(lo[31:0], hi[31:0], {$urandom, $urandom}, {$urandom, $urandom},
				$urandom, 1'($urandom_range(0, 1)));
			@(posedge clk);
			src_max_gap = (p % 4 == 0 || p % 4 == 3) ? 0 : 7;
			sink_max_gap = (p % 2 == 1) ? 7 : 0;
			if (p == 0) begin
				rx_hold = HOLD_CYCLES;
			end
			for (int i = 0; i < VALUES_PER_PHASE; i++) begin
				push_random(lo, hi);
			end
		end

		wait_drained();
		$display("Mapped %0d input values into %0d output values under %0d register settings",
			acc_in_cnt, acc_out_cnt, settings_cnt);
		$display("(%0d register writes, %0d failures)", cfg_acc_cnt, fail_cnt);
		if (fail_cnt == 0 && out_expected.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
